FILE: rtl/core/bta_pkg.sv
// ----------------------------------------------------------------------------
// bta_pkg: shared types and constants for the boundary tag hole allocator
// Word layouts for the request and response channels, operation, status and
// policy codes, and the sequencer state and write-job encodings.
// ----------------------------------------------------------------------------
package bta_pkg;

    // Arena size default and fixed field width of the channel words
    localparam int ARENA_WORDS_DEF = 4096;
    localparam int FIELD_W         = 12;

    // Smallest block payload, whole-fill slack and tag overhead in words
    localparam int MIN_REQ    = 3;
    localparam int FILL_SLACK = 4;
    localparam int TAG_OVH    = 2;

    // Register index of the fit policy
    localparam logic REG_FIT_POLICY = 1'b0;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_BADADDR = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_NEXT  = 2'd2,
        FIT_WORST = 2'd3
    } fit_t;

    typedef struct packed {
        logic                opcode;
        logic [FIELD_W-1:0]  request_size;
        logic [FIELD_W-1:0]  release_address;
    } req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [FIELD_W-1:0]  block_address;
        logic [FIELD_W-1:0]  granted_size;
        logic [FIELD_W-1:0]  holes_examined;
    } rsp_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_INIT0,
        S_INIT1,
        S_IDLE,
        S_A_TAG,
        S_A_NXT,
        S_A_DO,
        S_R_WALK,
        S_R_LEFT,
        S_R_RIGHT,
        S_L1,
        S_L2,
        S_L3,
        S_WR,
        S_OUT
    } state_t;

    // Write jobs run by the write state, one arena word per cycle
    typedef enum logic [2:0] {
        J_FILL,
        J_TAGS,
        J_SPLIT,
        J_UNLINK,
        J_REPL
    } job_t;

    // What the link read sequence is for
    typedef enum logic [1:0] {
        LK_UNLINK,
        LK_RIGHT,
        LK_ISO
    } lmode_t;

endpackage

FILE: rtl/core/bta_arena.sv
// ----------------------------------------------------------------------------
// bta_arena: arena tag memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bta_arena #(
    parameter int AW = 12,
    parameter int WW = 14
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] wa,
    input  logic [WW-1:0] wd,
    input  logic [AW-1:0] ra,
    output logic [WW-1:0] rd
);

    logic [WW-1:0] mem [2**AW];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd <= mem[ra];
    end

endmodule

FILE: rtl/core/bta_seq.sv
// ----------------------------------------------------------------------------
// bta_seq: allocator sequencer
// Walks the hole list and the tag chain one arena read per step, then runs
// short write jobs that update tags and links one word per cycle.
// ----------------------------------------------------------------------------
module bta_seq
    import bta_pkg::*;
#(
    parameter int ARENA_WORDS = ARENA_WORDS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  req_t                              req_data,
    input  fit_t                              fit_policy,
    output logic                              res_valid,
    input  logic                              res_free,
    output rsp_t                              res_data,
    output logic                              mem_we,
    output logic [$clog2(ARENA_WORDS)-1:0]    mem_wa,
    output logic [$clog2(ARENA_WORDS)+1:0]    mem_wd,
    output logic [$clog2(ARENA_WORDS)-1:0]    mem_ra,
    input  logic [$clog2(ARENA_WORDS)+1:0]    mem_rd
);

    localparam int AW = $clog2(ARENA_WORDS);
    localparam int WW = AW + 2;
    localparam int PW = ((AW > FIELD_W) ? AW : FIELD_W) + 1;
    localparam logic [PW-1:0] N_P    = PW'(ARENA_WORDS);
    localparam logic [PW-1:0] TWO_P  = PW'(TAG_OVH);
    localparam logic [PW-1:0] MIN_P  = PW'(MIN_REQ);
    localparam logic [PW-1:0] SLK_P  = PW'(FILL_SLACK);
    localparam logic [PW-1:0] ONE_P  = PW'(1);
    localparam logic [AW-1:0] LAST_A = AW'(ARENA_WORDS - 1);

    // Tag word helpers
    function automatic logic [PW-1:0] f_lnk(input logic [WW-1:0] v);
        f_lnk = v[WW-1] ? '0 : PW'(v[WW-2:0]);
    endfunction

    function automatic logic [PW-1:0] f_abs(input logic [WW-1:0] v);
        logic [WW-1:0] n;
        n = -v;
        f_abs = v[WW-1] ? PW'(n[WW-2:0]) : PW'(v[WW-2:0]);
    endfunction

    function automatic logic [WW-1:0] f_word(input logic [PW-1:0] x, input logic ng);
        logic [WW-1:0] w;
        w = WW'(x);
        f_word = ng ? -w : w;
    endfunction

    state_t           state_reg, state_next;
    job_t             job_reg, job_next;
    lmode_t           lmode_reg, lmode_next;
    logic [1:0]       wi_reg, wi_next;
    logic             rel_reg, rel_next;
    logic             found_reg, found_next;
    logic             first_reg, first_next;
    logic             neg_reg, neg_next;
    logic             self_reg, self_next;
    logic             left_reg, left_next;
    logic             empty_reg, empty_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [PW-1:0]    size_reg, size_next;
    logic [PW-1:0]    it_reg, it_next;
    logic [PW-1:0]    start_reg, start_next;
    logic [PW-1:0]    best_reg, best_next;
    logic [PW-1:0]    chosen_reg, chosen_next;
    logic [PW-1:0]    ba_reg, ba_next;
    logic [PW-1:0]    sz_reg, sz_next;
    logic [PW-1:0]    lo_reg, lo_next;
    logic [PW-1:0]    tot_reg, tot_next;
    logic [PW-1:0]    pl_reg, pl_next;
    logic [PW-1:0]    sl_reg, sl_next;
    logic [PW-1:0]    tgt_reg, tgt_next;
    logic [PW-1:0]    ls_reg, ls_next;
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    rover_reg, rover_next;
    logic [FIELD_W-1:0] cnt_reg, cnt_next;
    status_t          status_reg, status_next;

    // Shared decode of the word just read
    logic          rd_neg;
    logic [PW-1:0] rd_lnk, rd_hs, rd_abs;
    logic [PW-1:0] in_size, size_eff;
    logic [PW-1:0] p_new, r_addr, lo_left, slack;
    logic          tag_fit, wrap, walk_hit, walk_ok, pn_ok, right, l3_self;
    logic          last_wr, scan_first;
    logic [1:0]    nwr;
    logic [PW-1:0] ra_w, wa_w;

    assign rd_neg   = mem_rd[WW-1];
    assign rd_lnk   = f_lnk(mem_rd);
    assign rd_abs   = f_abs(mem_rd);
    assign rd_hs    = rd_neg ? rd_abs : '0;
    assign in_size  = PW'(req_data.request_size);
    assign size_eff = (in_size < MIN_P) ? MIN_P : in_size;
    assign p_new    = it_reg + rd_abs + TWO_P;
    assign r_addr   = ba_reg + sz_reg + TWO_P;
    assign lo_left  = ba_reg - ls_reg - TWO_P;
    assign slack    = best_reg - size_reg;
    assign tag_fit  = rd_hs >= size_reg;
    assign wrap     = rd_lnk == start_reg;
    assign walk_hit = it_reg == ba_reg;
    assign walk_ok  = !rd_neg && (|mem_rd);
    assign pn_ok    = (p_new < N_P) && (p_new <= ba_reg);
    assign right    = (r_addr < N_P) && rd_neg;
    assign l3_self  = pl_reg == tgt_reg;
    assign scan_first = (fit_policy == FIT_FIRST) || (fit_policy == FIT_NEXT);
    assign nwr      = (job_reg == J_SPLIT || (job_reg == J_REPL && !self_reg)) ? 2'd3 : 2'd1;
    assign last_wr  = wi_reg == nwr;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                if (clr_reg == LAST_A)
                begin
                    state_next = S_INIT0;
                end
            end
            S_INIT0: state_next = S_INIT1;
            S_INIT1: state_next = S_IDLE;
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_data.opcode == OP_RELEASE)
                    begin
                        state_next = S_R_WALK;
                    end
                    else
                    begin
                        state_next = empty_reg ? S_OUT : S_A_TAG;
                    end
                end
            end
            S_A_TAG: state_next = (scan_first && tag_fit) ? S_A_DO : S_A_NXT;
            S_A_NXT:
            begin
                if (!wrap)
                begin
                    state_next = S_A_TAG;
                end
                else if (fit_policy == FIT_BEST)
                begin
                    state_next = found_reg ? S_A_DO : S_OUT;
                end
                else if (fit_policy == FIT_WORST)
                begin
                    state_next = (best_reg >= size_reg) ? S_A_DO : S_OUT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_A_DO: state_next = S_WR;
            S_R_WALK:
            begin
                if (walk_hit)
                begin
                    state_next = walk_ok ? S_R_LEFT : S_OUT;
                end
                else
                begin
                    state_next = pn_ok ? S_R_WALK : S_OUT;
                end
            end
            S_R_LEFT: state_next = S_R_RIGHT;
            S_R_RIGHT:
            begin
                if (right)
                begin
                    state_next = S_L1;
                end
                else if (left_reg || empty_reg)
                begin
                    state_next = S_WR;
                end
                else
                begin
                    state_next = S_L1;
                end
            end
            S_L1: state_next = S_L2;
            S_L2: state_next = S_L3;
            S_L3:
            begin
                if (lmode_reg == LK_UNLINK && l3_self && !rel_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                if (last_wr)
                begin
                    case (job_reg)
                        J_FILL:   state_next = S_L1;
                        J_REPL:   state_next = S_WR;
                        J_UNLINK: state_next = rel_reg ? S_WR : S_OUT;
                        default:  state_next = S_OUT;
                    endcase
                end
            end
            S_OUT:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        job_next    = job_reg;
        lmode_next  = lmode_reg;
        wi_next     = wi_reg;
        rel_next    = rel_reg;
        found_next  = found_reg;
        first_next  = first_reg;
        neg_next    = neg_reg;
        self_next   = self_reg;
        left_next   = left_reg;
        empty_next  = empty_reg;
        clr_next    = clr_reg;
        size_next   = size_reg;
        it_next     = it_reg;
        start_next  = start_reg;
        best_next   = best_reg;
        chosen_next = chosen_reg;
        ba_next     = ba_reg;
        sz_next     = sz_reg;
        lo_next     = lo_reg;
        tot_next    = tot_reg;
        pl_next     = pl_reg;
        sl_next     = sl_reg;
        tgt_next    = tgt_reg;
        ls_next     = ls_reg;
        head_next   = head_reg;
        rover_next  = rover_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        ra_w        = '0;
        wa_w        = '0;
        mem_we      = 1'b0;
        mem_wd      = '0;
        case (state_reg)
            // Clearing pass, then the single hole over the whole arena
            S_CLR:
            begin
                mem_we   = 1'b1;
                wa_w     = PW'(clr_reg);
                clr_next = clr_reg + AW'(1);
            end
            S_INIT0:
            begin
                mem_we = 1'b1;
                wa_w   = '0;
                mem_wd = f_word(N_P - TWO_P, 1'b1);
            end
            S_INIT1:
            begin
                mem_we = 1'b1;
                wa_w   = N_P - ONE_P;
                mem_wd = f_word(N_P - TWO_P, 1'b1);
            end
            S_IDLE:
            begin
                status_next = ST_DONE;
                cnt_next    = '0;
                sz_next     = '0;
                found_next  = 1'b0;
                first_next  = 1'b1;
                best_next   = '0;
                size_next   = size_eff;
                if (req_data.opcode == OP_RELEASE)
                begin
                    rel_next = 1'b1;
                    ba_next  = PW'(req_data.release_address);
                    it_next  = '0;
                    ra_w     = '0;
                end
                else
                begin
                    rel_next   = 1'b0;
                    ba_next    = '0;
                    start_next = (fit_policy == FIT_NEXT) ? rover_reg : head_reg;
                    it_next    = (fit_policy == FIT_NEXT) ? rover_reg : head_reg;
                    ra_w       = (fit_policy == FIT_NEXT) ? rover_reg : head_reg;
                    if (empty_reg)
                    begin
                        status_next = ST_NOFIT;
                    end
                end
            end
            // Hole list search: tag read, then link read
            S_A_TAG:
            begin
                cnt_next   = (&cnt_reg) ? cnt_reg : cnt_reg + FIELD_W'(1);
                first_next = 1'b0;
                ra_w       = it_reg + TWO_P;
                if (scan_first)
                begin
                    if (tag_fit)
                    begin
                        chosen_next = it_reg;
                        best_next   = rd_hs;
                        found_next  = 1'b1;
                    end
                end
                else if (fit_policy == FIT_BEST)
                begin
                    if (tag_fit && (!found_reg || rd_hs < best_reg))
                    begin
                        chosen_next = it_reg;
                        best_next   = rd_hs;
                        found_next  = 1'b1;
                    end
                end
                else if (first_reg || rd_hs > best_reg)
                begin
                    chosen_next = it_reg;
                    best_next   = rd_hs;
                end
            end
            S_A_NXT:
            begin
                it_next = rd_lnk;
                ra_w    = rd_lnk;
                if (wrap)
                begin
                    if (!((fit_policy == FIT_BEST && found_reg) ||
                          (fit_policy == FIT_WORST && best_reg >= size_reg)))
                    begin
                        status_next = ST_NOFIT;
                    end
                end
            end
            // Fill the chosen hole whole or cut a block off its tail
            S_A_DO:
            begin
                wi_next = '0;
                lo_next = chosen_reg;
                if (fit_policy == FIT_NEXT)
                begin
                    rover_next = chosen_reg;
                end
                if (slack <= SLK_P)
                begin
                    job_next   = J_FILL;
                    tot_next   = best_reg;
                    neg_next   = 1'b0;
                    ba_next    = chosen_reg;
                    sz_next    = best_reg;
                    tgt_next   = chosen_reg;
                    lmode_next = LK_UNLINK;
                end
                else
                begin
                    job_next = J_SPLIT;
                    tot_next = slack - TWO_P;
                    neg_next = 1'b1;
                    ba_next  = chosen_reg + slack;
                    sz_next  = size_reg;
                end
            end
            // Release: walk the tag chain from word 0
            S_R_WALK:
            begin
                if (walk_hit)
                begin
                    if (walk_ok)
                    begin
                        sz_next = rd_abs;
                        ra_w    = ba_reg - ONE_P;
                    end
                    else
                    begin
                        status_next = ST_BADADDR;
                        ba_next     = '0;
                    end
                end
                else
                begin
                    it_next = p_new;
                    ra_w    = p_new;
                    if (!pn_ok)
                    begin
                        status_next = ST_BADADDR;
                        ba_next     = '0;
                    end
                end
            end
            S_R_LEFT:
            begin
                left_next = (|ba_reg) && rd_neg;
                ls_next   = rd_hs;
                ra_w      = r_addr;
            end
            S_R_RIGHT:
            begin
                neg_next = 1'b1;
                wi_next  = '0;
                if (left_reg && right)
                begin
                    lo_next    = lo_left;
                    tot_next   = r_addr + rd_hs - lo_left;
                    tgt_next   = r_addr;
                    lmode_next = LK_UNLINK;
                end
                else if (left_reg)
                begin
                    lo_next  = lo_left;
                    tot_next = ba_reg + sz_reg - lo_left;
                    job_next = J_TAGS;
                end
                else if (right)
                begin
                    lo_next    = ba_reg;
                    tot_next   = sz_reg + TWO_P + rd_hs;
                    tgt_next   = r_addr;
                    lmode_next = LK_RIGHT;
                end
                else
                begin
                    lo_next  = ba_reg;
                    tot_next = sz_reg;
                    if (empty_reg)
                    begin
                        job_next   = J_REPL;
                        self_next  = 1'b1;
                        head_next  = ba_reg;
                        rover_next = ba_reg;
                        empty_next = 1'b0;
                    end
                    else
                    begin
                        lmode_next = LK_ISO;
                        tgt_next   = head_reg;
                    end
                end
            end
            // Link reads of the target hole
            S_L1:
            begin
                ra_w = tgt_reg + ONE_P;
            end
            S_L2:
            begin
                pl_next = rd_lnk;
                ra_w    = tgt_reg + TWO_P;
            end
            S_L3:
            begin
                wi_next = '0;
                sl_next = (lmode_reg == LK_ISO) ? head_reg : rd_lnk;
                case (lmode_reg)
                    LK_UNLINK:
                    begin
                        if (l3_self)
                        begin
                            empty_next = 1'b1;
                            job_next   = J_TAGS;
                        end
                        else
                        begin
                            job_next = J_UNLINK;
                            if (head_reg == tgt_reg)
                            begin
                                head_next = rd_lnk;
                            end
                            if (rover_reg == tgt_reg)
                            begin
                                rover_next = rd_lnk;
                            end
                        end
                    end
                    LK_RIGHT:
                    begin
                        job_next  = J_REPL;
                        self_next = l3_self;
                        if (head_reg == tgt_reg)
                        begin
                            head_next = ba_reg;
                        end
                        if (rover_reg == tgt_reg)
                        begin
                            rover_next = ba_reg;
                        end
                    end
                    default:
                    begin
                        job_next  = J_REPL;
                        self_next = 1'b0;
                    end
                endcase
            end
            // One arena word per cycle from the current job
            S_WR:
            begin
                mem_we  = 1'b1;
                wi_next = wi_reg + 2'd1;
                case (job_reg)
                    J_UNLINK:
                    begin
                        wa_w   = (wi_reg == 2'd0) ? pl_reg + TWO_P : sl_reg + ONE_P;
                        mem_wd = f_word((wi_reg == 2'd0) ? sl_reg : pl_reg, 1'b0);
                    end
                    J_REPL:
                    begin
                        case (wi_reg)
                            2'd0:
                            begin
                                wa_w   = ba_reg + ONE_P;
                                mem_wd = f_word(self_reg ? ba_reg : pl_reg, 1'b0);
                            end
                            2'd1:
                            begin
                                wa_w   = ba_reg + TWO_P;
                                mem_wd = f_word(self_reg ? ba_reg : sl_reg, 1'b0);
                            end
                            2'd2:
                            begin
                                wa_w   = pl_reg + TWO_P;
                                mem_wd = f_word(ba_reg, 1'b0);
                            end
                            default:
                            begin
                                wa_w   = sl_reg + ONE_P;
                                mem_wd = f_word(ba_reg, 1'b0);
                            end
                        endcase
                    end
                    default:
                    begin
                        case (wi_reg)
                            2'd0:
                            begin
                                wa_w   = lo_reg;
                                mem_wd = f_word(tot_reg, neg_reg);
                            end
                            2'd1:
                            begin
                                wa_w   = lo_reg + tot_reg + ONE_P;
                                mem_wd = f_word(tot_reg, neg_reg);
                            end
                            2'd2:
                            begin
                                wa_w   = ba_reg;
                                mem_wd = f_word(sz_reg, 1'b0);
                            end
                            default:
                            begin
                                wa_w   = ba_reg + sz_reg + ONE_P;
                                mem_wd = f_word(sz_reg, 1'b0);
                            end
                        endcase
                    end
                endcase
                if (last_wr)
                begin
                    wi_next = '0;
                    if (job_reg == J_REPL || (job_reg == J_UNLINK && rel_reg))
                    begin
                        job_next = J_TAGS;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign mem_ra    = ra_w[AW-1:0];
    assign mem_wa    = wa_w[AW-1:0];
    assign req_ready = state_reg == S_IDLE;
    assign res_valid = state_reg == S_OUT;

    // Result word
    always_comb
    begin
        res_data.status         = status_reg;
        res_data.block_address  = FIELD_W'(ba_reg);
        res_data.granted_size   = FIELD_W'(sz_reg);
        res_data.holes_examined = cnt_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            empty_reg <= 1'b0;
            head_reg  <= '0;
            rover_reg <= '0;
            wi_reg    <= '0;
            job_reg   <= J_TAGS;
            lmode_reg <= LK_UNLINK;
            rel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            empty_reg <= empty_next;
            head_reg  <= head_next;
            rover_reg <= rover_next;
            wi_reg    <= wi_next;
            job_reg   <= job_next;
            lmode_reg <= lmode_next;
            rel_reg   <= rel_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        first_reg  <= first_next;
        neg_reg    <= neg_next;
        self_reg   <= self_next;
        left_reg   <= left_next;
        size_reg   <= size_next;
        it_reg     <= it_next;
        start_reg  <= start_next;
        best_reg   <= best_next;
        chosen_reg <= chosen_next;
        ba_reg     <= ba_next;
        sz_reg     <= sz_next;
        lo_reg     <= lo_next;
        tot_reg    <= tot_next;
        pl_reg     <= pl_next;
        sl_reg     <= sl_next;
        tgt_reg    <= tgt_next;
        ls_reg     <= ls_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
    end

endmodule

FILE: rtl/core/boundary_tag_hole_allocator.sv
// ----------------------------------------------------------------------------
// boundary_tag_hole_allocator: boundary tag hole allocator, top level
// Channel  Dir  Handshake                  Word
// req      in   req_valid / req_ready      req_t: opcode, size, address
// rsp      out  rsp_valid / rsp_ready      rsp_t: status, address, size, holes
// cfg      in   APB psel/penable/pwrite    fit_policy at byte address 0
//
// After reset a clearing pass writes every arena word, and the tags of one hole
// over the whole arena, before the first request word is taken. An allocate reads
// the tag and the link of each hole visited on the list, then runs tag and link
// updates; a release walks the regions from word 0, then runs its tag and link updates.
// All of it is bound by the single read port of the arena memory. A finished
// response sits in an output register while the next request is taken.
// ----------------------------------------------------------------------------
module boundary_tag_hole_allocator
    import bta_pkg::*;
#(
    parameter int ARENA_WORDS = ARENA_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req_data,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(ARENA_WORDS);
    localparam int WW = AW + 2;

    fit_t          fit_reg, fit_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_data_reg, rsp_data_next;
    logic          res_valid, res_free;
    rsp_t          res_data;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [WW-1:0] mem_wd, mem_rd;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FIT_POLICY) ? 32'(fit_reg) : '0;

    always_comb
    begin
        fit_next = fit_reg;
        if (psel && penable && pwrite && paddr[2] == REG_FIT_POLICY)
        begin
            fit_next = fit_t'(pwdata[1:0]);
        end
    end

    // Response output register
    assign res_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (res_valid && res_free)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = res_data;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_reg       <= FIT_FIRST;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fit_reg       <= fit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    // Sequencer and arena memory
    bta_seq #(
        .ARENA_WORDS (ARENA_WORDS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .fit_policy (fit_reg),
        .res_valid  (res_valid),
        .res_free   (res_free),
        .res_data   (res_data),
        .mem_we     (mem_we),
        .mem_wa     (mem_wa),
        .mem_wd     (mem_wd),
        .mem_ra     (mem_ra),
        .mem_rd     (mem_rd)
    );

    bta_arena #(
        .AW (AW),
        .WW (WW)
    ) u_arena (
        .clk (clk),
        .we  (mem_we),
        .wa  (mem_wa),
        .wd  (mem_wd),
        .ra  (mem_ra),
        .rd  (mem_rd)
    );

endmodule
